/* hw/rtl/wfht_pkg.sv */
// ----------------------------------------------------------------------------
// wfht_pkg
// Shared types, constants and codes for the word frequency hash table.
// ----------------------------------------------------------------------------
package wfht_pkg;

  localparam int TABLE_SIZE   = 4096;
  localparam int PROBE_STEP   = 13;
  localparam int PROBE_LIMIT  = 102;
  localparam int MAX_WORD_LEN = 31;
  localparam int HASH_BIAS    = 5003;

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int CIDX_W = $clog2(MAX_WORD_LEN);
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1) + 1;
  localparam int SLEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W  = 32;
  localparam int META_W = 1 + SLEN_W + CNT_W;

  // request codes
  localparam logic [1:0] REQ_DICT   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_COUNTED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_READ      = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_PROBE_RD, S_PROBE_EV, S_COPY,
    S_CMP_RD, S_CMP_EV, S_RD_META, S_RD_EV, S_RD_CHR, S_RD_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_step;
    logic    absorb;
    logic    load_idx;
    logic    load_home;
    logic    advance;
    logic    meta_rd;
    logic    meta_wr_ins;
    logic    meta_wr_cnt;
    logic    chr_rd;
    logic    chr_wr;
    logic    i_clr;
    logic    i_inc;
    logic    emit;
    status_t emit_status;
    logic    finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic overlong;
    logic len_zero;
    logic mode_cnt;
    logic used;
    logic len_match;
    logic chr_eq;
    logic first_probe;
    logic ins_last;
    logic cnt_last;
    logic i_last;
    logic rd_last;
  } sts_t;

endpackage

/* hw/rtl/word_frequency_hash_table.sv */
// ----------------------------------------------------------------------------
// word_frequency_hash_table
// Open addressing hash table of words with saturating per-word sample counts.
// ----------------------------------------------------------------------------
// A non-final character leaves busy low, so the block takes one per cycle.
// A word end is finished by probing slots, then copying each character on
// insert or comparing each character on count; the slot metadata memory
// port and the shared character memory port pace these steps.
// A read returns a result per stored character, or one for an empty slot;
// results strobe the cycle after they are issued. After reset a clearing
// pass over all 4096 slots holds busy high; results cannot be stalled.
module word_frequency_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  next_char,
  input  logic        word_end,
  input  logic [11:0] slot_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [11:0] slot,
  output logic        occupied,
  output logic [7:0]  out_char,
  output logic [31:0] frequency,
  output logic        last_result
);
  import wfht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wfht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .word_end (word_end),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  wfht_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .next_char   (next_char),
    .slot_index  (slot_index),
    .done        (done),
    .status      (status),
    .slot        (slot),
    .occupied    (occupied),
    .out_char    (out_char),
    .frequency   (frequency),
    .last_result (last_result)
  );

endmodule

/* hw/rtl/wfht_dp.sv */
// ----------------------------------------------------------------------------
// wfht_dp
// Datapath: hash fold, pending word, slot memories, probe and output registers.
// ----------------------------------------------------------------------------
module wfht_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  wfht_pkg::cmd_t              cmd,
  output wfht_pkg::sts_t              sts,
  input  logic [1:0]                  req_type,
  input  logic [7:0]                  next_char,
  input  logic [11:0]                 slot_index,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [11:0]                 slot,
  output logic                        occupied,
  output logic [7:0]                  out_char,
  output logic [31:0]                 frequency,
  output logic                        last_result
);
  import wfht_pkg::*;

  localparam logic [SLOT_W-1:0] BIAS  = SLOT_W'(HASH_BIAS % TABLE_SIZE);
  localparam logic [SLOT_W-1:0] STEP  = SLOT_W'(PROBE_STEP % TABLE_SIZE);
  localparam logic [SLOT_W-1:0] N_INS = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W-1:0] N_CNT = SLOT_W'(PROBE_LIMIT - 1);

  logic [SLOT_W-1:0]       hash_q;
  logic [LEN_W-1:0]        plen;
  logic                    ovf;
  logic                    mode_q;
  logic [7:0]              pend [MAX_WORD_LEN];
  logic [SLOT_W-1:0]       cur;
  logic [SLOT_W-1:0]       nprobe;
  logic [CIDX_W-1:0]       ci;
  logic [SLOT_W-1:0]       clr;
  logic [META_W-1:0]       meta [TABLE_SIZE];
  logic [META_W-1:0]       meta_q;
  logic [7:0]              chars [TABLE_SIZE * (1 << CIDX_W)];
  logic [7:0]              chr_q;
  logic [SLOT_W-1:0]       prod;
  logic                    m_used;
  logic [SLEN_W-1:0]       m_len;
  logic [CNT_W-1:0]        m_cnt;
  logic [CNT_W-1:0]        cnt_inc;
  logic [SLEN_W-1:0]       rlen;
  logic [SLOT_W+CIDX_W-1:0] caddr;

  assign prod    = SLOT_W'(next_char) * (hash_q + BIAS);
  assign m_used  = meta_q[META_W-1];
  assign m_len   = meta_q[CNT_W +: SLEN_W];
  assign m_cnt   = meta_q[CNT_W-1:0];
  assign cnt_inc = (&m_cnt) ? m_cnt : m_cnt + CNT_W'(1);
  assign rlen    = (m_len == '0) ? SLEN_W'(1) : m_len;
  assign caddr   = {cur, ci};

  // status back to the controller
  always_comb begin
    sts.clr_last    = (clr == N_INS);
    sts.overlong    = ovf;
    sts.len_zero    = (plen == '0);
    sts.mode_cnt    = mode_q;
    sts.used        = m_used;
    sts.len_match   = (LEN_W'(m_len) == plen);
    sts.chr_eq      = (chr_q == pend[ci]);
    sts.first_probe = (nprobe == '0);
    sts.ins_last    = (nprobe == N_INS);
    sts.cnt_last    = (nprobe == N_CNT);
    sts.i_last      = (LEN_W'(ci) + LEN_W'(1) == plen);
    sts.rd_last     = (SLEN_W'(ci) + SLEN_W'(1) == rlen);
  end

  // fold characters into the hash and hold the pending word
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_q <= '0;
      plen   <= '0;
      ovf    <= 1'b0;
      mode_q <= 1'b0;
    end else if (cmd.finish) begin
      hash_q <= '0;
      plen   <= '0;
      ovf    <= 1'b0;
    end else if (cmd.absorb) begin
      mode_q <= req_type[0];
      if (next_char != 8'd0) begin
        hash_q <= hash_q + prod[SLOT_W-1:0];
        if (plen < LEN_W'(MAX_WORD_LEN)) begin
          pend[plen[CIDX_W-1:0]] <= next_char;
          plen                   <= plen + LEN_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  // probe slot, probe count, character index and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + SLOT_W'(1);
    end
    if (cmd.load_idx) begin
      cur <= slot_index;
    end else if (cmd.load_home) begin
      cur    <= hash_q;
      nprobe <= '0;
    end else if (cmd.advance) begin
      cur    <= cur + STEP;
      nprobe <= nprobe + SLOT_W'(1);
    end
    if (cmd.i_clr) begin
      ci <= '0;
    end else if (cmd.i_inc) begin
      ci <= ci + CIDX_W'(1);
    end
  end

  // slot metadata memory: used, length, count
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      meta[clr] <= '0;
    end else if (cmd.meta_wr_ins) begin
      meta[cur] <= {1'b1, plen[SLEN_W-1:0], CNT_W'(0)};
    end else if (cmd.meta_wr_cnt) begin
      meta[cur] <= {1'b1, m_len, cnt_inc};
    end
    if (cmd.meta_rd) begin
      meta_q <= meta[cur];
    end
  end

  // stored word characters
  always_ff @(posedge clk) begin
    if (cmd.chr_wr) begin
      chars[caddr] <= pend[ci];
    end
    if (cmd.chr_rd) begin
      chr_q <= chars[caddr];
    end
  end

  // result registers, one cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      occupied    <= 1'b0;
      out_char    <= 8'd0;
      frequency   <= '0;
      last_result <= 1'b1;
      case (cmd.emit_status)
        ST_INSERTED:  slot <= cur;
        ST_COUNTED: begin
          slot      <= cur;
          frequency <= cnt_inc;
        end
        ST_NOT_FOUND, ST_FULL: slot <= hash_q;
        ST_READ: begin
          slot <= cur;
          if (m_used) begin
            occupied    <= 1'b1;
            out_char    <= chr_q;
            frequency   <= m_cnt;
            last_result <= sts.rd_last;
          end
        end
        default: slot <= '0;
      endcase
    end
  end

endmodule

/* hw/rtl/wfht_ctrl.sv */
// ----------------------------------------------------------------------------
// wfht_ctrl
// Controller: sequences clearing, word finish, probing, compare and read out.
// ----------------------------------------------------------------------------
module wfht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     req_type,
  input  logic           word_end,
  input  wfht_pkg::sts_t sts,
  output wfht_pkg::cmd_t cmd,
  output logic           busy
);
  import wfht_pkg::*;

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_READ) begin
            state_next = S_RD_META;
          end else if ((req_type == REQ_DICT || req_type == REQ_SAMPLE) && word_end) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK:    state_next = (sts.overlong || sts.len_zero) ? S_IDLE : S_PROBE_RD;
      S_PROBE_RD: state_next = S_PROBE_EV;
      S_PROBE_EV: begin
        if (!sts.mode_cnt) begin
          if (!sts.used)        state_next = S_COPY;
          else if (sts.ins_last) state_next = S_IDLE;
          else                  state_next = S_PROBE_RD;
        end else begin
          if (sts.first_probe && !sts.used)  state_next = S_IDLE;
          else if (sts.used && sts.len_match) state_next = S_CMP_RD;
          else if (sts.cnt_last)             state_next = S_IDLE;
          else                               state_next = S_PROBE_RD;
        end
      end
      S_COPY:     if (sts.i_last) state_next = S_IDLE;
      S_CMP_RD:   state_next = S_CMP_EV;
      S_CMP_EV: begin
        if (sts.chr_eq) begin
          state_next = sts.i_last ? S_IDLE : S_CMP_RD;
        end else begin
          state_next = sts.cnt_last ? S_IDLE : S_PROBE_RD;
        end
      end
      S_RD_META:  state_next = S_RD_EV;
      S_RD_EV:    state_next = sts.used ? S_RD_CHR : S_IDLE;
      S_RD_CHR:   state_next = S_RD_OUT;
      S_RD_OUT:   state_next = sts.rd_last ? S_IDLE : S_RD_CHR;
      default:    state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd             = '0;
    cmd.emit_status = ST_INSERTED;
    busy            = (state != S_IDLE);
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        if (start) begin
          cmd.load_idx = (req_type == REQ_READ);
          cmd.absorb   = (req_type == REQ_DICT || req_type == REQ_SAMPLE);
        end
      end
      S_CHECK: begin
        if (sts.overlong) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_TOO_LONG;
          cmd.finish      = 1'b1;
        end else if (sts.len_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_EMPTY;
          cmd.finish      = 1'b1;
        end else begin
          cmd.load_home = 1'b1;
        end
      end
      S_PROBE_RD: cmd.meta_rd = 1'b1;
      S_PROBE_EV: begin
        if (!sts.mode_cnt) begin
          if (!sts.used) begin
            cmd.meta_wr_ins = 1'b1;
            cmd.i_clr       = 1'b1;
          end else if (sts.ins_last) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_FULL;
            cmd.finish      = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          if ((sts.first_probe && !sts.used) ||
              (!(sts.used && sts.len_match) && sts.cnt_last)) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NOT_FOUND;
            cmd.finish      = 1'b1;
          end else if (sts.used && sts.len_match) begin
            cmd.i_clr = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_COPY: begin
        cmd.chr_wr = 1'b1;
        cmd.i_inc  = 1'b1;
        if (sts.i_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_INSERTED;
          cmd.finish      = 1'b1;
        end
      end
      S_CMP_RD: cmd.chr_rd = 1'b1;
      S_CMP_EV: begin
        if (sts.chr_eq) begin
          if (sts.i_last) begin
            cmd.meta_wr_cnt = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_COUNTED;
            cmd.finish      = 1'b1;
          end else begin
            cmd.i_inc = 1'b1;
          end
        end else if (sts.cnt_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NOT_FOUND;
          cmd.finish      = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RD_META: cmd.meta_rd = 1'b1;
      S_RD_EV: begin
        cmd.i_clr = 1'b1;
        if (!sts.used) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_READ;
        end
      end
      S_RD_CHR: cmd.chr_rd = 1'b1;
      S_RD_OUT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_READ;
        cmd.i_inc       = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/wfht_checker.sv */
// ----------------------------------------------------------------------------
// wfht_checker
// Port level checks on results of the word frequency hash table.
// ----------------------------------------------------------------------------
module wfht_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        occupied,
  input logic [7:0]  out_char,
  input logic [31:0] frequency,
  input logic        last_result
);
  import wfht_pkg::*;

  // clearing pass holds the block busy straight after reset
  a_busy_after_rst: assert property (@(posedge clk) $past(rst) && rst |=> busy)
    else $error("block not busy after reset");

  // only a read transfer reports an occupied slot
  a_occ_read: assert property (@(posedge clk) disable iff (rst)
    done && occupied |-> status == ST_READ)
    else $error("occupied set on a non-read result");

  // characters come only from occupied slots
  a_char_occ: assert property (@(posedge clk) disable iff (rst)
    done && out_char != 8'd0 |-> occupied)
    else $error("character on an empty result");

  // word results are single transfers
  a_word_last: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_READ |-> last_result)
    else $error("word result not marked last");

  // frequency is zero except on counted or occupied read results
  a_freq_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_COUNTED && !occupied |-> frequency == 32'd0)
    else $error("stray frequency");

endmodule

bind word_frequency_hash_table wfht_checker u_wfht_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .occupied    (occupied),
  .out_char    (out_char),
  .frequency   (frequency),
  .last_result (last_result)
);

/* sim/tb_word_frequency_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_word_frequency_hash_table
// Streams dictionary and sample words, slot reads and noise into the hash
// table with bursty input timing; a scoreboard predicts every result strobe.
// ----------------------------------------------------------------------------
module tb_word_frequency_hash_table;
  import wfht_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         NUM_ITEMS  = 360;
  localparam int         CYCLE_CAP  = 400000;
  localparam int         MAX_CHARS  = 40;

  typedef struct {
    logic [7:0] c [MAX_CHARS];
    int         n;
  } word_t;

  typedef struct {
    status_t     status;
    logic [11:0] slot;
    logic        occupied;
    logic [7:0]  out_char;
    logic [31:0] frequency;
    logic        last_result;
  } result_t;

  // Scoreboard: holds its own copy of the table and the pending word
  class freq_table_scoreboard;
    bit          used [TABLE_SIZE];
    logic [7:0]  chars [TABLE_SIZE][MAX_WORD_LEN];
    int          lens [TABLE_SIZE];
    logic [31:0] counts [TABLE_SIZE];
    logic [7:0]  pend [MAX_WORD_LEN];
    int          pend_len;
    int          hash;
    bit          overlong;
    result_t     pending_results [$];
    int          filled_slots [$];
    int          failures;

    function void push(status_t st, int s, logic occ, logic [7:0] ch,
                       logic [31:0] f, logic last);
      result_t r;
      r.status = st; r.slot = s[11:0]; r.occupied = occ;
      r.out_char = ch; r.frequency = f; r.last_result = last;
      pending_results.push_back(r);
    endfunction

    function bit same_word(int j);
      if (!used[j] || lens[j] != pend_len) return 0;
      for (int i = 0; i < pend_len; i++)
        if (chars[j][i] != pend[i]) return 0;
      return 1;
    endfunction

    // Close the pending word in dictionary or sample mode
    function void close_word(logic [1:0] mode);
      int j;
      int n;
      bit hit;
      j = hash;
      hit = 0;
      if (overlong) push(ST_TOO_LONG, 0, 0, 0, 0, 1);
      else if (pend_len == 0) push(ST_EMPTY, 0, 0, 0, 0, 1);
      else if (mode == REQ_DICT) begin
        for (n = 0; n < TABLE_SIZE; n++) begin
          if (!used[j]) begin
            hit = 1;
            break;
          end
          j = (j + PROBE_STEP) % TABLE_SIZE;
        end
        if (hit) begin
          used[j] = 1;
          lens[j] = pend_len;
          for (int i = 0; i < pend_len; i++) chars[j][i] = pend[i];
          counts[j] = 0;
          filled_slots.push_back(j);
          push(ST_INSERTED, j, 0, 0, 0, 1);
        end else push(ST_FULL, hash, 0, 0, 0, 1);
      end else if (!used[hash]) push(ST_NOT_FOUND, hash, 0, 0, 0, 1);
      else begin
        for (n = 0; n < PROBE_LIMIT; n++) begin
          if (same_word(j)) begin
            hit = 1;
            break;
          end
          j = (j + PROBE_STEP) % TABLE_SIZE;
        end
        if (hit) begin
          if (counts[j] != 32'hFFFF_FFFF) counts[j]++;
          push(ST_COUNTED, j, 0, 0, counts[j], 1);
        end else push(ST_NOT_FOUND, hash, 0, 0, 0, 1);
      end
      hash = 0;
      pend_len = 0;
      overlong = 0;
    endfunction

    function void note_transfer(logic [1:0] rt, logic [7:0] ch, logic we,
                                logic [11:0] idx);
      int s;
      int len;
      s = idx % TABLE_SIZE;
      if (rt == REQ_READ) begin
        if (!used[s]) push(ST_READ, s, 0, 0, 0, 1);
        else begin
          len = lens[s];
          if (len == 0 || len > MAX_WORD_LEN) len = 1;
          for (int i = 0; i < len; i++)
            push(ST_READ, s, 1, chars[s][i], counts[s], i + 1 == len);
        end
        return;
      end
      if (rt == REQ_UNUSED) return;
      if (ch != 0) begin
        hash = (hash + ch * (hash + HASH_BIAS)) % TABLE_SIZE;
        if (pend_len < MAX_WORD_LEN) begin
          pend[pend_len] = ch;
          pend_len++;
        end else overlong = 1;
      end
      if (we) close_word(rt);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", got.status, got.slot);
        failures++;
        return;
      end
      w = pending_results.pop_front();
      if (got.status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, got.status);
        failures++;
      end
      if (got.slot !== w.slot) begin
        $error("slot: expected %0d, got %0d", w.slot, got.slot);
        failures++;
      end
      if (got.occupied !== w.occupied) begin
        $error("occupied: expected %0d, got %0d", w.occupied, got.occupied);
        failures++;
      end
      if (got.out_char !== w.out_char) begin
        $error("out_char: expected %0h, got %0h", w.out_char, got.out_char);
        failures++;
      end
      if (got.frequency !== w.frequency) begin
        $error("frequency: expected %0d, got %0d", w.frequency, got.frequency);
        failures++;
      end
      if (got.last_result !== w.last_result) begin
        $error("last_result: expected %0d, got %0d", w.last_result,
               got.last_result);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [7:0]  next_char;
  logic        word_end;
  logic [11:0] slot_index;
  logic        done;
  logic [2:0]  status;
  logic [11:0] slot;
  logic        occupied;
  logic [7:0]  out_char;
  logic [31:0] frequency;
  logic        last_result;

  freq_table_scoreboard sb;
  word_t                lexicon [$];
  int                   items_sent;
  int                   burst_left;
  int                   cycles;

  word_frequency_hash_table DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .next_char(next_char), .word_end(word_end),
    .slot_index(slot_index), .done(done), .status(status), .slot(slot),
    .occupied(occupied), .out_char(out_char), .frequency(frequency),
    .last_result(last_result)
  );

  always #5 clk = ~clk;

  // Check every result strobe against the oldest prediction
  always @(posedge clk) begin
    result_t r;
    if (!rst && done) begin
      r.status = status_t'(status); r.slot = slot; r.occupied = occupied;
      r.out_char = out_char; r.frequency = frequency;
      r.last_result = last_result;
      sb.check_result(r);
    end
  end

  // Give up at a generous cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("word_frequency_hash_table verification failed");
      $finish;
    end
  end

  // Hold one item until the transfer, then idle per the burst pattern
  task automatic drive(logic [1:0] rt, logic [7:0] ch, logic we, logic [11:0] idx);
    int gap;
    start <= 1'b1;
    req_type <= rt; next_char <= ch; word_end <= we; slot_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_transfer(rt, ch, we, idx);
    items_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        req_type <= 2'($urandom); next_char <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic read_slot(bit from_used);
    logic [11:0] idx;
    idx = 12'($urandom);
    if (from_used && sb.filled_slots.size() > 0)
      idx = sb.filled_slots[$urandom_range(0, sb.filled_slots.size() - 1)];
    drive(REQ_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  // Send a word; the final item carries the mode, earlier ones a random one
  task automatic send_word(logic [1:0] mode, word_t w, bit pad_end, bit noisy);
    logic [1:0] rt;
    bit last;
    for (int i = 0; i < w.n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) read_slot($urandom_range(0, 1));
      if (noisy && $urandom_range(0, 14) == 0)
        drive(REQ_UNUSED, 8'($urandom), 1'($urandom), 12'($urandom));
      last = (i == w.n - 1) && !pad_end;
      rt = last ? mode : ($urandom_range(0, 1) ? REQ_SAMPLE : REQ_DICT);
      drive(rt, w.c[i], last, 12'($urandom));
    end
    if (pad_end) drive(mode, 8'd0, 1'b1, 12'($urandom));
    if (mode == REQ_DICT && w.n > 0 && w.n <= MAX_WORD_LEN) lexicon.push_back(w);
  endtask

  function automatic word_t make_word(int n, bit any_byte);
    word_t w;
    w.n = n;
    for (int i = 0; i < MAX_CHARS; i++)
      w.c[i] = any_byte ? 8'($urandom_range(1, 255)) : 8'($urandom_range(97, 122));
    return w;
  endfunction

  initial begin
    word_t w;
    int    pick;
    clk = 0; rst = 1; start = 0; req_type = REQ_DICT; next_char = 0;
    word_end = 0; slot_index = 0; cycles = 0; items_sent = 0; burst_left = 0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty word, extremes of characters, duplicates, counting
    drive(REQ_DICT, 8'd0, 1'b1, 12'hFFF);
    w = make_word(1, 0); w.c[0] = 8'hFF;
    send_word(REQ_DICT, w, 0, 0);
    w.c[0] = 8'h01;
    send_word(REQ_DICT, w, 1, 0);
    send_word(REQ_DICT, w, 0, 0);
    send_word(REQ_SAMPLE, w, 0, 0);
    send_word(REQ_SAMPLE, w, 0, 0);
    w = make_word(MAX_WORD_LEN, 1);
    send_word(REQ_DICT, w, 0, 0);
    send_word(REQ_SAMPLE, w, 0, 0);
    read_slot(1);
    w = make_word(MAX_WORD_LEN + 1, 0);
    send_word(REQ_SAMPLE, w, 0, 0);
    w = make_word(3, 0);
    send_word(REQ_SAMPLE, w, 0, 0);
    drive(REQ_UNUSED, 8'hFF, 1'b1, 12'hFFF);
    drive(REQ_READ, 8'h00, 1'b0, 12'hFFF);
    drive(REQ_READ, 8'h00, 1'b0, 12'h000);

    // Random: words reused from the dictionary, fresh or odd words and slot reads
    while (items_sent < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && lexicon.size() > 0)
        send_word(REQ_SAMPLE, lexicon[$urandom_range(0, lexicon.size() - 1)],
                  $urandom_range(0, 4) == 0, 1);
      else if (pick < 45 && lexicon.size() > 0)
        send_word(REQ_DICT, lexicon[$urandom_range(0, lexicon.size() - 1)],
                  $urandom_range(0, 4) == 0, 1);
      else if (pick < 75)
        send_word(REQ_DICT, make_word($urandom_range(1, 8), $urandom_range(0, 3) == 0),
                  $urandom_range(0, 4) == 0, 1);
      else if (pick < 85)
        send_word(REQ_SAMPLE, make_word($urandom_range(1, 6), 0), 0, 1);
      else if (pick < 90)
        send_word($urandom_range(0, 1) ? REQ_SAMPLE : REQ_DICT,
                  make_word($urandom_range(MAX_WORD_LEN - 1, MAX_CHARS), 1),
                  $urandom_range(0, 1), 0);
      else if (pick < 93)
        drive($urandom_range(0, 1) ? REQ_SAMPLE : REQ_DICT, 8'd0, 1'b1, 12'($urandom));
      else read_slot($urandom_range(0, 3) != 0);
    end

    start <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.failures == 0)
      $display("word_frequency_hash_table verification clean");
    else
      $display("word_frequency_hash_table verification failed");
    $finish;
  end

endmodule
